// ===== rtl/g94_pkg.sv =====
// g94_pkg: shared types, constants and functions of the hash core
// holds the beat structs, state codes, s-box, step constant and the
// a, p, psi and round transforms; depends on nothing
package g94_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [63:0] hash_word3;
    logic [63:0] hash_word2;
    logic [63:0] hash_word1;
    logic [63:0] hash_word0;
  } out_t;

  // byte i of a block sits in bits 8i+7:8i
  typedef logic [31:0][7:0] blk_t;

  typedef struct packed {
    logic        absorb;
    logic        fin;
    logic [63:0] len;
    blk_t        blk;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_KEY, ST_ENC, ST_PSI_A, ST_MIX, ST_PSI_B, ST_OUT
  } state_t;

  typedef enum logic [1:0] {PH_BLK, PH_LEN, PH_SUM} phase_t;

  localparam int unsigned FifoDepth = 2;

  localparam logic [255:0] C3 =
    256'hFF00FFFF000000FF_FF0000FF00FFFF00_00FF00FF00FF00FF_FF00FF00FF00FF00;

  localparam logic [3:0] SBOX [0:7][0:15] = '{
    '{4'd10, 4'd4, 4'd5, 4'd6, 4'd8, 4'd1, 4'd3, 4'd7,
      4'd13, 4'd12, 4'd14, 4'd0, 4'd9, 4'd2, 4'd11, 4'd15},
    '{4'd5, 4'd15, 4'd4, 4'd0, 4'd2, 4'd13, 4'd11, 4'd9,
      4'd1, 4'd7, 4'd6, 4'd3, 4'd12, 4'd14, 4'd10, 4'd8},
    '{4'd7, 4'd15, 4'd12, 4'd14, 4'd9, 4'd4, 4'd1, 4'd0,
      4'd3, 4'd11, 4'd5, 4'd2, 4'd6, 4'd10, 4'd8, 4'd13},
    '{4'd4, 4'd10, 4'd7, 4'd12, 4'd0, 4'd15, 4'd2, 4'd8,
      4'd14, 4'd1, 4'd6, 4'd5, 4'd13, 4'd11, 4'd9, 4'd3},
    '{4'd7, 4'd6, 4'd4, 4'd11, 4'd9, 4'd12, 4'd2, 4'd10,
      4'd1, 4'd8, 4'd0, 4'd14, 4'd15, 4'd13, 4'd3, 4'd5},
    '{4'd7, 4'd6, 4'd2, 4'd4, 4'd13, 4'd9, 4'd15, 4'd0,
      4'd10, 4'd1, 4'd5, 4'd11, 4'd8, 4'd14, 4'd12, 4'd3},
    '{4'd13, 4'd14, 4'd4, 4'd1, 4'd7, 4'd0, 4'd5, 4'd10,
      4'd3, 4'd12, 4'd8, 4'd15, 4'd6, 4'd2, 4'd9, 4'd11},
    '{4'd1, 4'd3, 4'd10, 4'd9, 4'd5, 4'd11, 4'd4, 4'd15,
      4'd8, 4'd6, 4'd7, 4'd14, 4'd13, 4'd0, 4'd2, 4'd12}
  };

  function automatic logic [31:0] round_fn(input logic [31:0] a, input logic [31:0] k);
    logic [31:0] x;
    logic [31:0] y;
    x = a + k;
    for (int i = 0; i < 8; i++) begin
      y[4*i +: 4] = SBOX[i][x[4*i +: 4]];
    end
    return {y[20:0], y[31:21]};
  endfunction

  function automatic logic [255:0] xform_a(input logic [255:0] y);
    return {y[63:0] ^ y[127:64], y[255:64]};
  endfunction

  function automatic blk_t xform_p(input blk_t y);
    blk_t r;
    for (int i = 0; i < 32; i++) begin
      r[i] = y[((i % 4) * 8) + (i / 4)];
    end
    return r;
  endfunction

  function automatic logic [255:0] psi1(input logic [255:0] s);
    logic [15:0] x;
    x = s[15:0] ^ s[31:16] ^ s[47:32] ^ s[63:48] ^ s[207:192] ^ s[255:240];
    return {x, s[255:16]};
  endfunction

  function automatic logic [255:0] psi4(input logic [255:0] s);
    return psi1(psi1(psi1(psi1(s))));
  endfunction

endpackage

// ===== rtl/gost94_hash_stream_core.sv =====
// gost94_hash_stream_core: byte stream hash core, top level
// joins g94_front, g94_cmd_fifo and g94_back; uses g94_pkg
//
//   port group   dir   beat                      handshake
//   in_*         in    one byte + flags (in_t)   in_valid / in_stall
//   out_*        out   256-bit hash (out_t)      out_valid / out_stall
//
// one input beat per cycle while the command queue has room
// each 32-byte block passes through the compression engine in order:
//   pop, start, key generation, 32 cipher rounds on four lanes, psi mixing
// end of message adds two more compressions (length, sum), one more before
//   them for a partial tail block, then the result stage
// reset: synchronous, active low; clears chain, sum, length and queue
// in_stall rises while the two-entry command queue is full
module gost94_hash_stream_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  g94_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output g94_pkg::out_t out_data
);

  logic          acc;
  logic          push, pop, not_empty, full;
  g94_pkg::cmd_t wr_cmd, rd_cmd;

  // stall depends only on queue fill, never on valid
  assign in_stall = full;
  assign acc      = in_valid && !in_stall;

  // front: gathers bytes and builds block / finalize commands
  g94_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_data (in_data),
    .push    (push),
    .cmd     (wr_cmd)
  );

  // queue lets the front keep taking bytes during a compression
  g94_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_cmd    (wr_cmd),
    .pop       (pop),
    .not_empty (not_empty),
    .full      (full),
    .rd_cmd    (rd_cmd)
  );

  // back: sum, step function and registered result
  g94_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (not_empty),
    .cmd       (rd_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/g94_front.sv =====
// g94_front: byte gatherer, bit length counter and command builder
// turns input beats into block and finalize commands; uses g94_pkg
module g94_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  g94_pkg::in_t  in_data,
  output logic          push,
  output g94_pkg::cmd_t cmd
);

  g94_pkg::blk_t buf_r, buf_nxt;
  logic [4:0]    fill_r, fill_nxt;
  logic [63:0]   len_r, len_nxt;
  g94_pkg::blk_t blk_new;
  logic          absorb;

  always_comb begin
    blk_new = buf_r;
    if (in_data.byte_valid) begin
      blk_new[fill_r] = in_data.data_byte;
    end
    fill_nxt = fill_r + {4'd0, in_data.byte_valid};
    len_nxt  = len_r + (in_data.byte_valid ? 64'd8 : 64'd0);
    // full block, or a partial tail at end of message
    absorb = (in_data.byte_valid && (fill_r == 5'd31)) ||
             (in_data.end_of_message && (fill_nxt != 5'd0));
    push = acc && (absorb || in_data.end_of_message);
    cmd.absorb = absorb;
    cmd.fin    = in_data.end_of_message;
    cmd.len    = len_nxt;
    cmd.blk    = blk_new;
    buf_nxt    = (absorb || in_data.end_of_message) ? '0 : blk_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r  <= '0;
      fill_r <= '0;
      len_r  <= '0;
    end else if (acc) begin
      buf_r  <= buf_nxt;
      fill_r <= in_data.end_of_message ? 5'd0 : fill_nxt;
      len_r  <= in_data.end_of_message ? 64'd0 : len_nxt;
    end
  end

endmodule

// ===== rtl/g94_cmd_fifo.sv =====
// g94_cmd_fifo: short command queue between gatherer and compression engine
// uses g94_pkg for the command type and depth
module g94_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  g94_pkg::cmd_t wr_cmd,
  input  logic          pop,
  output logic          not_empty,
  output logic          full,
  output g94_pkg::cmd_t rd_cmd
);

  g94_pkg::cmd_t mem_r [g94_pkg::FifoDepth];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;

  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'(g94_pkg::FifoDepth));
  assign rd_cmd    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= 2'(g94_pkg::FifoDepth)) && !(push && full) && !(pop && !not_empty))
    else $error("command queue over or underflow");

endmodule

// ===== rtl/g94_back.sv =====
// g94_back: compression engine, block sum and result register
// key generation, four cipher lanes, psi mixing; uses g94_pkg
module g94_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  g94_pkg::cmd_t  cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output g94_pkg::out_t  out_data
);

  g94_pkg::state_t state_r, state_nxt;
  g94_pkg::phase_t phase_r;
  logic            fin_r;
  logic [63:0]     len_r;
  logic [4:0]      cnt_r;
  logic            out_load;
  logic            out_valid_r;
  g94_pkg::out_t   out_r;

  logic [255:0]           chain_r, m_r, u_r, v_r, s_r;
  logic [3:0][63:0]       sum_r;
  logic                   carry_r;
  logic [3:0][7:0][31:0]  key_r;
  logic [31:0]            n1_r [4];
  logic [31:0]            n2_r [4];
  logic [2:0]             kidx;
  logic [64:0]            add_w;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= g94_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      g94_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          pop       = 1'b1;
          state_nxt = g94_pkg::ST_START;
        end
      end
      g94_pkg::ST_START: state_nxt = g94_pkg::ST_KEY;
      g94_pkg::ST_KEY:   if (cnt_r == 5'd3) state_nxt = g94_pkg::ST_ENC;
      g94_pkg::ST_ENC:   if (cnt_r == 5'd31) state_nxt = g94_pkg::ST_PSI_A;
      g94_pkg::ST_PSI_A: if (cnt_r == 5'd2) state_nxt = g94_pkg::ST_MIX;
      g94_pkg::ST_MIX:   state_nxt = g94_pkg::ST_PSI_B;
      g94_pkg::ST_PSI_B: begin
        if (cnt_r == 5'd15) begin
          if (phase_r == g94_pkg::PH_SUM)                state_nxt = g94_pkg::ST_OUT;
          else if (phase_r == g94_pkg::PH_BLK && !fin_r) state_nxt = g94_pkg::ST_IDLE;
          else                                           state_nxt = g94_pkg::ST_START;
        end
      end
      g94_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = g94_pkg::ST_IDLE;
        end
      end
      default: state_nxt = g94_pkg::ST_IDLE;
    endcase
  end

  // round key order: words 0..7 three times, then 7..0
  assign kidx  = (cnt_r < 5'd24) ? cnt_r[2:0] : ~cnt_r[2:0];
  assign add_w = {1'b0, sum_r[cnt_r[1:0]]} + {1'b0, m_r[64*cnt_r[1:0] +: 64]} +
                 {64'd0, carry_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r     <= '0;
      sum_r       <= '0;
      carry_r     <= 1'b0;
      phase_r     <= g94_pkg::PH_BLK;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      cnt_r <= (state_nxt != state_r) ? 5'd0 : cnt_r + 5'd1;
      if (out_load) begin
        out_valid_r <= 1'b1;
        chain_r     <= '0;
        sum_r       <= '0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        g94_pkg::ST_IDLE: begin
          if (pop) begin
            phase_r <= cmd.absorb ? g94_pkg::PH_BLK : g94_pkg::PH_LEN;
            fin_r   <= cmd.fin;
          end
        end
        g94_pkg::ST_START: carry_r <= 1'b0;
        g94_pkg::ST_KEY: begin
          if (phase_r == g94_pkg::PH_BLK) begin
            sum_r[cnt_r[1:0]] <= add_w[63:0];
            carry_r           <= add_w[64];
          end
        end
        g94_pkg::ST_PSI_B: begin
          if (cnt_r == 5'd15) begin
            chain_r <= g94_pkg::psi1(s_r);
            if (phase_r == g94_pkg::PH_BLK)      phase_r <= g94_pkg::PH_LEN;
            else if (phase_r == g94_pkg::PH_LEN) phase_r <= g94_pkg::PH_SUM;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state_r)
      g94_pkg::ST_IDLE: begin
        if (pop) begin
          m_r   <= cmd.blk;
          len_r <= cmd.len;
        end
      end
      g94_pkg::ST_START: begin
        if (phase_r == g94_pkg::PH_BLK) begin
          u_r <= chain_r;
          v_r <= m_r;
        end else if (phase_r == g94_pkg::PH_LEN) begin
          m_r <= {192'd0, len_r};
          u_r <= chain_r;
          v_r <= {192'd0, len_r};
        end else begin
          m_r <= sum_r;
          u_r <= chain_r;
          v_r <= sum_r;
        end
        for (int l = 0; l < 4; l++) begin
          n1_r[l] <= chain_r[64*l +: 32];
          n2_r[l] <= chain_r[64*l+32 +: 32];
        end
      end
      g94_pkg::ST_KEY: begin
        key_r[cnt_r[1:0]] <= g94_pkg::xform_p(u_r ^ v_r);
        u_r <= g94_pkg::xform_a(u_r) ^ ((cnt_r[1:0] == 2'd1) ? g94_pkg::C3 : 256'd0);
        v_r <= g94_pkg::xform_a(g94_pkg::xform_a(v_r));
      end
      g94_pkg::ST_ENC: begin
        for (int l = 0; l < 4; l++) begin
          n1_r[l] <= g94_pkg::round_fn(n1_r[l], key_r[l][kidx]) ^ n2_r[l];
          n2_r[l] <= n1_r[l];
        end
        if (cnt_r == 5'd31) begin
          for (int l = 0; l < 4; l++) begin
            s_r[64*l +: 64] <= {g94_pkg::round_fn(n1_r[l], key_r[l][kidx]) ^ n2_r[l],
                                n1_r[l]};
          end
        end
      end
      g94_pkg::ST_PSI_A: s_r <= g94_pkg::psi4(s_r);
      g94_pkg::ST_MIX:   s_r <= g94_pkg::psi1(s_r ^ m_r) ^ chain_r;
      g94_pkg::ST_PSI_B: if (cnt_r != 5'd15) s_r <= g94_pkg::psi4(s_r);
      default: ;
    endcase
    if (out_load) begin
      out_r.hash_word0 <= chain_r[63:0];
      out_r.hash_word1 <= chain_r[127:64];
      out_r.hash_word2 <= chain_r[191:128];
      out_r.hash_word3 <= chain_r[255:192];
    end
  end

  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == g94_pkg::ST_OUT))
    else $error("result raised outside final stage");

  a_chain_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (chain_r == '0) && (sum_r == '0))
    else $error("chain or sum not cleared after result");

  a_enc_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == g94_pkg::ST_ENC) |=>
      (state_r == g94_pkg::ST_ENC) || (state_r == g94_pkg::ST_PSI_A))
    else $error("cipher rounds cut short");

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for gost94_hash_stream_core
// predicts each 256-bit hash in software and compares the out_ beats;
// depends on g94_pkg and the core rtl
`timescale 1ns / 1ps
module testbench;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  g94_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  g94_pkg::out_t out_data;

  gost94_hash_stream_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // s-box rows of the cipher, one nibble per entry
  localparam logic [3:0] SB [0:7][0:15] = '{
    '{4'd10, 4'd4, 4'd5, 4'd6, 4'd8, 4'd1, 4'd3, 4'd7,
      4'd13, 4'd12, 4'd14, 4'd0, 4'd9, 4'd2, 4'd11, 4'd15},
    '{4'd5, 4'd15, 4'd4, 4'd0, 4'd2, 4'd13, 4'd11, 4'd9,
      4'd1, 4'd7, 4'd6, 4'd3, 4'd12, 4'd14, 4'd10, 4'd8},
    '{4'd7, 4'd15, 4'd12, 4'd14, 4'd9, 4'd4, 4'd1, 4'd0,
      4'd3, 4'd11, 4'd5, 4'd2, 4'd6, 4'd10, 4'd8, 4'd13},
    '{4'd4, 4'd10, 4'd7, 4'd12, 4'd0, 4'd15, 4'd2, 4'd8,
      4'd14, 4'd1, 4'd6, 4'd5, 4'd13, 4'd11, 4'd9, 4'd3},
    '{4'd7, 4'd6, 4'd4, 4'd11, 4'd9, 4'd12, 4'd2, 4'd10,
      4'd1, 4'd8, 4'd0, 4'd14, 4'd15, 4'd13, 4'd3, 4'd5},
    '{4'd7, 4'd6, 4'd2, 4'd4, 4'd13, 4'd9, 4'd15, 4'd0,
      4'd10, 4'd1, 4'd5, 4'd11, 4'd8, 4'd14, 4'd12, 4'd3},
    '{4'd13, 4'd14, 4'd4, 4'd1, 4'd7, 4'd0, 4'd5, 4'd10,
      4'd3, 4'd12, 4'd8, 4'd15, 4'd6, 4'd2, 4'd9, 4'd11},
    '{4'd1, 4'd3, 4'd10, 4'd9, 4'd5, 4'd11, 4'd4, 4'd15,
      4'd8, 4'd6, 4'd7, 4'd14, 4'd13, 4'd0, 4'd2, 4'd12}
  };
  // key step constant, byte i in bits 8i+7:8i
  localparam logic [255:0] STEP_C = {
    8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF,
    8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00,
    8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
    8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00
  };

  // predictor state of the message in progress
  logic [255:0] msg_block;
  int unsigned  msg_fill;
  logic [255:0] chain_h;
  logic [255:0] sum_h;
  logic [63:0]  len_bits;

  g94_pkg::in_t  pending_beats[$];
  g94_pkg::out_t expected_hashes[$];
  int   mismatches;
  bit   in_taken;
  bit   hold_req;
  bit   long_hold;
  int   sender_idle_pct;
  int   receiver_stall_pct;

  function automatic logic [255:0] shift_a(logic [255:0] y);
    return {y[63:0] ^ y[127:64], y[255:64]};
  endfunction

  function automatic logic [255:0] permute_p(logic [255:0] y);
    logic [255:0] r;
    for (int i = 0; i < 32; i++) r[8*i +: 8] = y[8*(((i & 3) << 3) + (i >> 2)) +: 8];
    return r;
  endfunction

  function automatic logic [31:0] feistel_f(logic [31:0] a, logic [31:0] k);
    logic [31:0] x;
    logic [31:0] y;
    x = a + k;
    for (int i = 0; i < 8; i++) y[4*i +: 4] = SB[i][x[4*i +: 4]];
    return {y[20:0], y[31:21]};
  endfunction

  function automatic logic [63:0] cipher64(logic [63:0] d, logic [255:0] kb);
    logic [31:0] n1;
    logic [31:0] n2;
    logic [31:0] t;
    logic [31:0] k;
    n1 = d[31:0];
    n2 = d[63:32];
    for (int r = 0; r < 32; r++) begin
      k = (r < 24) ? kb[32*(r & 7) +: 32] : kb[32*(7 - (r & 7)) +: 32];
      t = feistel_f(n1, k) ^ n2;
      n2 = n1;
      n1 = t;
    end
    return {n1, n2};
  endfunction

  function automatic logic [255:0] lfsr_psi(logic [255:0] s, int n);
    logic [15:0] x;
    for (int i = 0; i < n; i++) begin
      x = s[15:0] ^ s[31:16] ^ s[47:32] ^ s[63:48] ^ s[207:192] ^ s[255:240];
      s = {x, s[255:16]};
    end
    return s;
  endfunction

  function automatic logic [255:0] gost_step(logic [255:0] h, logic [255:0] m);
    logic [255:0] u;
    logic [255:0] v;
    logic [255:0] s;
    logic [255:0] keys [0:3];
    u = h;
    v = m;
    keys[0] = permute_p(u ^ v);
    for (int j = 1; j < 4; j++) begin
      u = shift_a(u) ^ ((j == 2) ? STEP_C : 256'd0);
      v = shift_a(shift_a(v));
      keys[j] = permute_p(u ^ v);
    end
    for (int k = 0; k < 4; k++) s[64*k +: 64] = cipher64(h[64*k +: 64], keys[k]);
    s = lfsr_psi(s, 12) ^ m;
    s = lfsr_psi(s, 1) ^ h;
    return lfsr_psi(s, 61);
  endfunction

  task automatic absorb_block();
    sum_h   = sum_h + msg_block;
    chain_h = gost_step(chain_h, msg_block);
  endtask

  task automatic clear_message();
    msg_block = '0;
    msg_fill  = 0;
    chain_h   = '0;
    sum_h     = '0;
    len_bits  = '0;
  endtask

  // run one beat through the predictor and queue the hash it yields
  task automatic predict_beat(g94_pkg::in_t b);
    if (b.byte_valid) begin
      msg_block[8*msg_fill +: 8] = b.data_byte;
      msg_fill = (msg_fill + 1) % 32;
      len_bits += 64'd8;
      if (msg_fill == 0) absorb_block();
    end
    if (b.end_of_message) begin
      if (msg_fill != 0) begin
        for (int i = int'(msg_fill); i < 32; i++) msg_block[8*i +: 8] = 8'h00;
        absorb_block();
      end
      chain_h = gost_step(chain_h, {192'd0, len_bits});
      chain_h = gost_step(chain_h, sum_h);
      expected_hashes.push_back(g94_pkg::out_t'(chain_h));
      clear_message();
    end
  endtask

  function automatic g94_pkg::in_t mk_beat(logic [7:0] d, logic bv, logic eom);
    g94_pkg::in_t b;
    b.data_byte      = d;
    b.byte_valid     = bv;
    b.end_of_message = eom;
    return b;
  endfunction

  // message of n random bytes; the last byte may carry the end flag itself
  task automatic queue_message(int n, bit end_on_byte);
    for (int i = 0; i < n; i++)
      pending_beats.push_back(mk_beat(8'($urandom_range(0, 255)), 1'b1,
                                      end_on_byte && (i == n - 1)));
    if (!end_on_byte || n == 0)
      pending_beats.push_back(mk_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1));
  endtask

  // predictor: takes each accepted beat at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken = 1'b0;
      clear_message();
    end else begin
      in_taken = in_valid && !in_stall;
      if (in_taken) predict_beat(in_data);
    end
  end

  // driver: applies beats at the falling edge, holds them while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || in_taken) begin
      if (pending_beats.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_data  <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, random or a long hold
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= long_hold || ($urandom_range(0, 99) < receiver_stall_pct);
  end

  // long receiver hold, counted in cycles once requested
  initial begin
    wait (hold_req);
    long_hold = 1'b1;
    repeat (600) @(posedge clk);
    long_hold = 1'b0;
  end

  // monitor: compare each accepted hash with the oldest prediction
  always @(posedge clk) begin
    g94_pkg::out_t exp_h;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_hashes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected hash beat %h", out_data);
      end else begin
        exp_h = expected_hashes.pop_front();
        if (exp_h.hash_word0 !== out_data.hash_word0 ||
            exp_h.hash_word1 !== out_data.hash_word1 ||
            exp_h.hash_word2 !== out_data.hash_word2 ||
            exp_h.hash_word3 !== out_data.hash_word3) begin
          mismatches++;
          if (mismatches <= 10)
            $display("hash mismatch: expected %h actual %h", exp_h, out_data);
        end
      end
    end
  end

  // watchdog
  int unsigned cycle_count;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2_000_000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_beats.size() > 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    int n;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty message, lone byte with end, extremes, block edges
    pending_beats.push_back(mk_beat(8'hFF, 1'b0, 1'b1));
    pending_beats.push_back(mk_beat(8'hFF, 1'b1, 1'b1));
    pending_beats.push_back(mk_beat(8'h00, 1'b0, 1'b0)); // ignored beat
    pending_beats.push_back(mk_beat(8'h00, 1'b1, 1'b1));
    for (int i = 0; i < 32; i++) pending_beats.push_back(mk_beat(8'h55, 1'b1, i == 31));
    for (int i = 0; i < 32; i++) pending_beats.push_back(mk_beat(8'hAA, 1'b1, 1'b0));
    pending_beats.push_back(mk_beat(8'h00, 1'b0, 1'b1)); // full block then empty end
    wait_drained();

    // random messages across idling phases
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = (phase == 1 || phase == 3) ? 54 : 0;
      receiver_stall_pct = (phase == 2) ? 54 : (phase == 3) ? 16 : 0;
      if (phase == 3) sender_idle_pct = 16;
      for (int m = 0; m < 16; m++) begin
        n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(60, 70))
                                        : int'($urandom_range(0, 40));
        queue_message(n, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0)
          pending_beats.push_back(mk_beat(8'($urandom), 1'b0, 1'b0));
      end
      // long receiver hold while the sender keeps offering beats
      if (phase == 0) hold_req = 1'b1;
      wait_drained();
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;

    while (expected_hashes.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_hashes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
